// ===== rtl/palette_nearest_shade_blend_assert.svh =====
// assertion macros for the palette nearest shade blend block
`ifndef PALETTE_NEAREST_SHADE_BLEND_ASSERT_SVH
`define PALETTE_NEAREST_SHADE_BLEND_ASSERT_SVH

// same-cycle implication
`define PNSB_ASSERT_NOW(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("palette unit assertion failed");

// next-cycle implication
`define PNSB_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("palette unit assertion failed");

`endif

// ===== rtl/pnsb_pkg.sv =====
// shared constants, types and helpers for the palette nearest shade blend block
`default_nettype none

package pnsb_pkg;

   localparam int PALETTE_SIZE = 256;
   localparam int SHADE_LEVELS = 64;
   localparam int IDX_W        = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

   localparam int SHADE_TOP    = SHADE_LEVELS - 1;
   localparam int RECIP_SHIFT  = 24;
   localparam int RECIP_W      = RECIP_SHIFT + 1;
   localparam logic [RECIP_W-1:0] RECIP_MULT =
      RECIP_W'(((2 ** RECIP_SHIFT) + SHADE_TOP - 1) / SHADE_TOP);

   localparam int BLEND_SCALE  = 1024;
   localparam int BLEND_WA     = 2048 / 3;
   localparam int BLEND_WB     = BLEND_SCALE - BLEND_WA;

   localparam int DIST_W = 18;
   localparam logic [DIST_W-1:0] DIST_INIT = '1;

   typedef enum logic [1:0] {
      REQ_WRITE   = 2'd0,
      REQ_NEAREST = 2'd1,
      REQ_SHADE   = 2'd2,
      REQ_BLEND   = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic       en;
      logic [7:0] index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } wr_type;

   typedef struct packed {
      logic              valid;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic [DIST_W-1:0] score;
      logic [7:0]        idx;
   } link_type;

   function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return 16'(d) * 16'(d);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pnsb_cell.sv =====
// one search cell: holds a palette entry and updates the running best match
`default_nettype none

module pnsb_cell import pnsb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] cell_index,
   input  wr_type     wr,
   input  link_type   link_in,
   output link_type   link_out
);

   logic [7:0]        ent_red_ff, ent_green_ff, ent_blue_ff;
   link_type          link_ff;
   link_type          link_in_c;
   logic [DIST_W-1:0] cand_score;

   always_comb begin
      cand_score = DIST_W'(sq_diff(link_in.red, ent_red_ff))
                 + DIST_W'(sq_diff(link_in.green, ent_green_ff))
                 + DIST_W'(sq_diff(link_in.blue, ent_blue_ff));
      link_in_c = link_in;
      if (cand_score < link_in.score) begin
         link_in_c.score = cand_score;
         link_in_c.idx   = cell_index;
      end
      if (reset) begin
         link_in_c.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.index == cell_index)) begin
         ent_red_ff   <= wr.red;
         ent_green_ff <= wr.green;
         ent_blue_ff  <= wr.blue;
      end
      link_ff <= link_in_c;
   end

   assign link_out = link_ff;

endmodule

`default_nettype wire

// ===== rtl/pnsb_chain.sv =====
// row of search cells, one per palette entry
`default_nettype none

module pnsb_chain import pnsb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  wr_type   wr,
   input  link_type link_in,
   output link_type link_out
);

   link_type links [PALETTE_SIZE+1];

   assign links[0] = link_in;

   for (genvar k = 0; k < PALETTE_SIZE; k++) begin : g_cell
      pnsb_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (8'(k)),
         .wr         (wr),
         .link_in    (links[k]),
         .link_out   (links[k+1])
      );
   end

   assign link_out = links[PALETTE_SIZE];

endmodule

`default_nettype wire

// ===== rtl/palette_nearest_shade_blend.sv =====
// Palette unit: a write word loads one palette entry and keeps busy low. A nearest
// query injects the query color into the row of 256 cells, where it walks one cell per
// cycle; the best match is registered as the result. A shade or blend query first reads
// the palette at acceptance and scales the colors in the fetch and scale states before
// the inject. Shade of entry zero and blend with an operand of zero answer in the cycle
// after acceptance. The result is shown for one cycle on rsp_valid and must be taken
// then; the receiver cannot stall the block.
`default_nettype none

module palette_nearest_shade_blend import pnsb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_type,
   input  logic [7:0] req_entry_index,
   input  logic [7:0] req_second_index,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic [5:0] req_light_level,
   output logic       rsp_valid,
   output logic [7:0] rsp_color_index
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCALE,
      ST_INJECT,
      ST_SEARCH
   } state_type;

   state_type    state_ff;
   req_kind_type kind_ff;
   logic [5:0]   factor_ff;
   logic [23:0]  palette_ff [PALETTE_SIZE];
   logic [23:0]  rd_a_ff, rd_b_ff;
   logic         a_ok_ff, b_ok_ff;
   logic [13:0]  prod_ff [3];
   logic [7:0]   target_ff [3];
   logic         rsp_valid_ff;
   logic [7:0]   rsp_index_ff;

   logic         accept;
   logic         rsp_valid_in;
   logic         a_in_range, b_in_range;
   logic [5:0]   light_sat;
   logic [23:0]  col_a, col_b;
   logic [13:0]  prod_in [3];
   logic [7:0]   target_in [3];
   logic [RECIP_W+13:0] recip [3];
   logic [17:0]  mix [3];
   wr_type       wr;
   link_type     link_in, link_out;

   assign accept     = start && !busy;
   assign busy       = (state_ff != ST_IDLE);
   assign a_in_range = ({1'b0, req_entry_index} < 9'(PALETTE_SIZE));
   assign b_in_range = ({1'b0, req_second_index} < 9'(PALETTE_SIZE));
   assign light_sat  = ({26'd0, req_light_level} > 32'(SHADE_TOP)) ?
                       6'(SHADE_TOP) : req_light_level;

   assign rsp_valid_in = (accept && (req_type == REQ_SHADE) && (req_entry_index == 8'd0))
                      || (accept && (req_type == REQ_BLEND)
                          && ((req_entry_index == 8'd0) || (req_second_index == 8'd0)))
                      || ((state_ff == ST_SEARCH) && link_out.valid);

   assign wr.en    = accept && (req_type == REQ_WRITE);
   assign wr.index = req_entry_index;
   assign wr.red   = req_red;
   assign wr.green = req_green;
   assign wr.blue  = req_blue;

   always_ff @(posedge clock) begin
      if (wr.en && a_in_range) begin
         palette_ff[req_entry_index[IDX_W-1:0]] <= {req_red, req_green, req_blue};
      end
      rd_a_ff <= palette_ff[req_entry_index[IDX_W-1:0]];
      rd_b_ff <= palette_ff[req_second_index[IDX_W-1:0]];
   end

   always_comb begin
      col_a = a_ok_ff ? rd_a_ff : 24'd0;
      col_b = b_ok_ff ? rd_b_ff : 24'd0;
      for (int c = 0; c < 3; c++) begin
         mix[c] = 18'(BLEND_WA) * 18'(col_a[23-8*c -: 8])
                + 18'(BLEND_WB) * 18'(col_b[23-8*c -: 8]);
         if (kind_ff == REQ_SHADE) begin
            prod_in[c] = 14'(col_a[23-8*c -: 8]) * 14'(factor_ff);
         end else begin
            prod_in[c] = {6'd0, mix[c][17:10]};
         end
         recip[c] = (RECIP_W+14)'(prod_ff[c]) * (RECIP_W+14)'(RECIP_MULT);
         if (kind_ff == REQ_SHADE) begin
            target_in[c] = recip[c][RECIP_SHIFT +: 8];
         end else begin
            target_in[c] = prod_ff[c][7:0];
         end
      end
   end

   assign link_in.valid = (state_ff == ST_INJECT);
   assign link_in.red   = target_ff[0];
   assign link_in.green = target_ff[1];
   assign link_in.blue  = target_ff[2];
   assign link_in.score = DIST_INIT;
   assign link_in.idx   = 8'd0;

   pnsb_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .link_in  (link_in),
      .link_out (link_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  kind_ff   <= req_kind_type'(req_type);
                  factor_ff <= 6'(SHADE_TOP) - light_sat;
                  a_ok_ff   <= a_in_range;
                  b_ok_ff   <= b_in_range;
                  unique case (req_kind_type'(req_type))
                     REQ_WRITE: begin
                     end
                     REQ_NEAREST: begin
                        target_ff[0] <= req_red;
                        target_ff[1] <= req_green;
                        target_ff[2] <= req_blue;
                        state_ff     <= ST_INJECT;
                     end
                     REQ_SHADE: begin
                        if (req_entry_index == 8'd0) begin
                           rsp_index_ff <= 8'd0;
                        end else begin
                           state_ff <= ST_FETCH;
                        end
                     end
                     REQ_BLEND: begin
                        if (req_entry_index == 8'd0) begin
                           rsp_index_ff <= req_second_index;
                        end else if (req_second_index == 8'd0) begin
                           rsp_index_ff <= req_entry_index;
                        end else begin
                           state_ff <= ST_FETCH;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_FETCH: begin
               prod_ff  <= prod_in;
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               target_ff <= target_in;
               state_ff  <= ST_INJECT;
            end
            ST_INJECT: begin
               state_ff <= ST_SEARCH;
            end
            ST_SEARCH: begin
               if (link_out.valid) begin
                  rsp_index_ff <= link_out.idx;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_index = rsp_index_ff;

endmodule

`default_nettype wire

// ===== rtl/pnsb_checker.sv =====
// port-level checks for the palette nearest shade blend block
`default_nettype none
`include "palette_nearest_shade_blend_assert.svh"

module pnsb_checker import pnsb_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_type,
   input logic [7:0] req_entry_index,
   input logic [7:0] req_second_index,
   input logic [7:0] req_red,
   input logic [7:0] req_green,
   input logic [7:0] req_blue,
   input logic [5:0] req_light_level,
   input logic       rsp_valid,
   input logic [7:0] rsp_color_index
);

   logic acc;
   assign acc = start && !busy;

   // a write word never produces a result
   `PNSB_ASSERT_NEXT(a_write_silent, clock, reset, acc && (req_type == REQ_WRITE), !rsp_valid)
   // a nearest query holds the block busy
   `PNSB_ASSERT_NEXT(a_nearest_busy, clock, reset, acc && (req_type == REQ_NEAREST), busy)
   // shade of entry zero answers zero at once
   `PNSB_ASSERT_NEXT(a_shade_zero, clock, reset,
      acc && (req_type == REQ_SHADE) && (req_entry_index == 8'd0),
      rsp_valid && (rsp_color_index == 8'd0))
   // blend with first operand zero answers the second operand
   `PNSB_ASSERT_NEXT(a_blend_zero, clock, reset,
      acc && (req_type == REQ_BLEND) && (req_entry_index == 8'd0),
      rsp_valid && (rsp_color_index == $past(req_second_index)))
   // the end of a search is marked by a result
   `PNSB_ASSERT_NOW(a_done_result, clock, reset, $fell(busy) && !$past(reset), rsp_valid)

endmodule

bind palette_nearest_shade_blend pnsb_checker u_checker (.*);

`default_nettype wire
